// ----- src/udp_frame_header_builder_defines.svh -----
// assertion macros used by the header builder back block
`ifndef UDP_FRAME_HEADER_BUILDER_DEFINES_SVH
`define UDP_FRAME_HEADER_BUILDER_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define UFHB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ufhb check failed");

// next-cycle implication under synchronous active-low reset
`define UFHB_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ufhb check failed");

`endif

// ----- src/ufhb_pkg.sv -----
package ufhb_pkg;

    localparam int QUEUE_W     = 6;
    localparam int PORT_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int OFFSET_W    = 6;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_MAC    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_MAC  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_IP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_IP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_PORT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PORT_SEED   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LEN   = 3'd6;

    localparam logic [15:0] DEST_PORT_RST = 16'd60000;
    localparam logic [15:0] PORT_SEED_RST = 16'd60001;
    localparam logic [11:0] FRAME_LEN_RST = 12'd60;

    localparam logic [31:0] PORT_HASH     = 32'h61C8_8647;

    // header layout
    localparam logic [OFFSET_W-1:0] HDR_LAST    = 6'd41;
    localparam logic [OFFSET_W-1:0] CSUM_WORDS  = 6'd10;
    localparam logic [15:0]         IP_HDR_OFS  = 16'd14;
    localparam logic [15:0]         UDP_HDR_OFS = 16'd34;
    localparam logic [15:0]         WORD_VER_TOS = 16'h4510;
    localparam logic [15:0]         WORD_TTL_UDP = 16'h1011;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] dest_ip;
        logic [31:0] source_ip;
        logic [15:0] dest_port;
        logic [15:0] source_port_seed;
        logic [11:0] frame_len;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_EMIT
    } back_state_t;

endpackage

// ----- src/ufhb_front.sv -----
module ufhb_front
    import ufhb_pkg::*;
#(
    parameter int QUEUE_COUNT = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [QUEUE_W-1:0]  s_queue_number,
    input  fifo_stat_t          fifo_stat,
    output logic                push,
    output logic [PORT_W-1:0]   push_port
);

    localparam int QUEUE_SPAN = 1 << QUEUE_W;
    localparam int QTAB_BITS  = QUEUE_SPAN * QUEUE_W;

    // queue reduction table, built at elaboration
    function automatic logic [QTAB_BITS-1:0] build_queue_table();
        logic [QTAB_BITS-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < QUEUE_SPAN; i++) begin
            tbl[i*QUEUE_W +: QUEUE_W] = QUEUE_W'(i % QUEUE_COUNT);
        end
        return tbl;
    endfunction

    localparam logic [QTAB_BITS-1:0] QUEUE_TABLE = build_queue_table();

    logic                front_valid_reg, front_valid_next;
    logic [PORT_W-1:0]   front_sum_reg, front_sum_next;
    logic [QUEUE_W-1:0]  queue_mod;
    logic [PORT_W-1:0]   seed_swapped;
    logic                accept;

    assign queue_mod    = QUEUE_TABLE[s_queue_number*QUEUE_W +: QUEUE_W];
    assign seed_swapped = {cfg.source_port_seed[7:0], cfg.source_port_seed[15:8]};

    assign push    = front_valid_reg && !fifo_stat.full;
    assign s_ready = !front_valid_reg || !fifo_stat.full;
    assign accept  = s_valid && s_ready;

    // only the low half of the product is kept
    assign push_port = PORT_W'(front_sum_reg * PORT_HASH[PORT_W-1:0]);

    always_comb begin
        front_valid_next = front_valid_reg;
        front_sum_next   = front_sum_reg;
        if (accept) begin
            front_valid_next = 1'b1;
            front_sum_next   = seed_swapped + PORT_W'(queue_mod);
        end else if (push) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
        front_sum_reg <= front_sum_next;
    end

endmodule

// ----- src/ufhb_fifo.sv -----
module ufhb_fifo
    import ufhb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [PORT_W-1:0]  push_port,
    input  logic               pop,
    output logic [PORT_W-1:0]  pop_port,
    output fifo_stat_t         fifo_stat
);

    logic [PORT_W-1:0] entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    assign fifo_stat.full  = (count_reg == 2'd2);
    assign fifo_stat.empty = (count_reg == 2'd0);
    assign pop_port        = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_port;
        end
    end

endmodule

// ----- src/ufhb_back.sv -----
`include "udp_frame_header_builder_defines.svh"

module ufhb_back
    import ufhb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  fifo_stat_t           fifo_stat,
    input  logic [PORT_W-1:0]    pop_port,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_W-1:0]    m_header_byte,
    output logic [OFFSET_W-1:0]  m_byte_offset,
    output logic                 m_last_byte
);

    back_state_t           state_reg, state_next;
    logic [OFFSET_W-1:0]   pos_reg, pos_next;
    logic [PORT_W-1:0]     port_reg, port_next;
    logic [15:0]           csum_reg, csum_next;
    logic                  m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]     m_header_byte_reg, m_header_byte_next;
    logic [OFFSET_W-1:0]   m_byte_offset_reg, m_byte_offset_next;
    logic                  m_last_byte_reg, m_last_byte_next;

    logic                  out_free;
    logic [15:0]           ip_len;
    logic [15:0]           udp_len;
    logic [15:0]           csum_word;
    logic [16:0]           csum_sum;
    logic [15:0]           csum_inv;
    logic [BYTE_W-1:0]     cur_byte;

    assign ip_len   = 16'(cfg.frame_len) - IP_HDR_OFS;
    assign udp_len  = 16'(cfg.frame_len) - UDP_HDR_OFS;
    assign csum_inv = ~csum_reg;
    assign out_free = !m_valid_reg || m_ready;

    // ip header words, one folded in per emitted byte while the position is below CSUM_WORDS
    always_comb begin
        case (pos_reg[3:0])
            4'd0:    csum_word = WORD_VER_TOS;
            4'd1:    csum_word = ip_len;
            4'd4:    csum_word = WORD_TTL_UDP;
            4'd6:    csum_word = cfg.source_ip[31:16];
            4'd7:    csum_word = cfg.source_ip[15:0];
            4'd8:    csum_word = cfg.dest_ip[31:16];
            4'd9:    csum_word = cfg.dest_ip[15:0];
            default: csum_word = 16'h0000;
        endcase
    end

    // end-around carry add
    assign csum_sum = 17'(csum_reg) + 17'(csum_word);

    always_comb begin
        case (pos_reg)
            6'd0:    cur_byte = cfg.dest_mac[47:40];
            6'd1:    cur_byte = cfg.dest_mac[39:32];
            6'd2:    cur_byte = cfg.dest_mac[31:24];
            6'd3:    cur_byte = cfg.dest_mac[23:16];
            6'd4:    cur_byte = cfg.dest_mac[15:8];
            6'd5:    cur_byte = cfg.dest_mac[7:0];
            6'd6:    cur_byte = cfg.source_mac[47:40];
            6'd7:    cur_byte = cfg.source_mac[39:32];
            6'd8:    cur_byte = cfg.source_mac[31:24];
            6'd9:    cur_byte = cfg.source_mac[23:16];
            6'd10:   cur_byte = cfg.source_mac[15:8];
            6'd11:   cur_byte = cfg.source_mac[7:0];
            6'd12:   cur_byte = 8'h08;
            6'd14:   cur_byte = WORD_VER_TOS[15:8];
            6'd15:   cur_byte = WORD_VER_TOS[7:0];
            6'd16:   cur_byte = ip_len[15:8];
            6'd17:   cur_byte = ip_len[7:0];
            6'd22:   cur_byte = WORD_TTL_UDP[15:8];
            6'd23:   cur_byte = WORD_TTL_UDP[7:0];
            6'd24:   cur_byte = csum_inv[15:8];
            6'd25:   cur_byte = csum_inv[7:0];
            6'd26:   cur_byte = cfg.source_ip[31:24];
            6'd27:   cur_byte = cfg.source_ip[23:16];
            6'd28:   cur_byte = cfg.source_ip[15:8];
            6'd29:   cur_byte = cfg.source_ip[7:0];
            6'd30:   cur_byte = cfg.dest_ip[31:24];
            6'd31:   cur_byte = cfg.dest_ip[23:16];
            6'd32:   cur_byte = cfg.dest_ip[15:8];
            6'd33:   cur_byte = cfg.dest_ip[7:0];
            6'd34:   cur_byte = port_reg[7:0];
            6'd35:   cur_byte = port_reg[15:8];
            6'd36:   cur_byte = cfg.dest_port[15:8];
            6'd37:   cur_byte = cfg.dest_port[7:0];
            6'd38:   cur_byte = udp_len[15:8];
            6'd39:   cur_byte = udp_len[7:0];
            default: cur_byte = 8'h00;
        endcase
    end

    always_comb begin
        state_next         = state_reg;
        pos_next           = pos_reg;
        port_next          = port_reg;
        csum_next          = csum_reg;
        pop                = 1'b0;
        m_valid_next       = m_valid_reg && !m_ready;
        m_header_byte_next = m_header_byte_reg;
        m_byte_offset_next = m_byte_offset_reg;
        m_last_byte_next   = m_last_byte_reg;
        unique case (state_reg)
            BACK_IDLE: begin
                if (!fifo_stat.empty) begin
                    pop        = 1'b1;
                    port_next  = pop_port;
                    pos_next   = '0;
                    csum_next  = '0;
                    state_next = BACK_EMIT;
                end
            end
            BACK_EMIT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_header_byte_next = cur_byte;
                    m_byte_offset_next = pos_reg;
                    m_last_byte_next   = (pos_reg == HDR_LAST);
                    if (pos_reg == HDR_LAST) begin
                        // chain straight into the next queued item
                        if (!fifo_stat.empty) begin
                            pop       = 1'b1;
                            port_next = pop_port;
                            pos_next  = '0;
                            csum_next = '0;
                        end else begin
                            state_next = BACK_IDLE;
                        end
                    end else begin
                        pos_next = pos_reg + 6'd1;
                        if (pos_reg < CSUM_WORDS) begin
                            csum_next = csum_sum[16] ? csum_sum[15:0] + 16'd1
                                                     : csum_sum[15:0];
                        end
                    end
                end
            end
            default: state_next = BACK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BACK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg           <= pos_next;
        port_reg          <= port_next;
        csum_reg          <= csum_next;
        m_header_byte_reg <= m_header_byte_next;
        m_byte_offset_reg <= m_byte_offset_next;
        m_last_byte_reg   <= m_last_byte_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_header_byte = m_header_byte_reg;
    assign m_byte_offset = m_byte_offset_reg;
    assign m_last_byte   = m_last_byte_reg;

    `UFHB_ASSERT_IMP(a_last_at_end, aclk, aresetn, m_valid_reg && m_last_byte_reg, m_byte_offset_reg == HDR_LAST)
    `UFHB_ASSERT_IMP(a_pop_not_empty, aclk, aresetn, pop, !fifo_stat.empty)
    `UFHB_ASSERT_IMP(a_pos_in_range, aclk, aresetn, state_reg == BACK_EMIT, pos_reg <= HDR_LAST)
    `UFHB_ASSERT_NXT(a_run_continues, aclk, aresetn, m_valid_reg && m_ready && !m_last_byte_reg, m_valid_reg)

endmodule

// ----- src/udp_frame_header_builder.sv -----
// request path: an accepted request is registered in the front stage, queued, then taken by the byte sequencer
// throughput: one header byte per cycle while m_ready is high, set by the byte-wide
//   output register; a queued request starts right after the previous last byte
// reset: synchronous active-low aresetn restores register defaults and empties the
//   front stage, queue and byte sequencer
module udp_frame_header_builder
    import ufhb_pkg::*;
#(
    parameter int QUEUE_COUNT = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration write port
    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wr_data,
    // request channel
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [QUEUE_W-1:0]      s_queue_number,
    // header byte channel
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [BYTE_W-1:0]       m_header_byte,
    output logic [OFFSET_W-1:0]     m_byte_offset,
    output logic                    m_last_byte
);

    // configuration registers, only the low bits of each write are kept
    cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEST_MAC:   cfg_next.dest_mac         = cfg_wr_data[47:0];
                REG_SOURCE_MAC: cfg_next.source_mac       = cfg_wr_data[47:0];
                REG_DEST_IP:    cfg_next.dest_ip          = cfg_wr_data[31:0];
                REG_SOURCE_IP:  cfg_next.source_ip        = cfg_wr_data[31:0];
                REG_DEST_PORT:  cfg_next.dest_port        = cfg_wr_data[15:0];
                REG_PORT_SEED:  cfg_next.source_port_seed = cfg_wr_data[15:0];
                REG_FRAME_LEN:  cfg_next.frame_len        = cfg_wr_data[11:0];
                // unused index, write dropped
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_mac         <= '0;
            cfg_reg.source_mac       <= '0;
            cfg_reg.dest_ip          <= '0;
            cfg_reg.source_ip        <= '0;
            cfg_reg.dest_port        <= DEST_PORT_RST;
            cfg_reg.source_port_seed <= PORT_SEED_RST;
            cfg_reg.frame_len        <= FRAME_LEN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front to back queue
    fifo_stat_t        fifo_stat;
    logic              push;
    logic [PORT_W-1:0] push_port;
    logic              pop;
    logic [PORT_W-1:0] pop_port;

    // front: takes the request, reduces the queue number and hashes the source port
    ufhb_front #(
        .QUEUE_COUNT(QUEUE_COUNT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_queue_number(s_queue_number),
        .fifo_stat     (fifo_stat),
        .push          (push),
        .push_port     (push_port)
    );

    // two-entry queue of hashed source ports
    ufhb_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_port(push_port),
        .pop      (pop),
        .pop_port (pop_port),
        .fifo_stat(fifo_stat)
    );

    // back: walks the 42 header byte positions, folds in the ip checksum on the way,
    // and drives the registered output
    ufhb_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .fifo_stat    (fifo_stat),
        .pop_port     (pop_port),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_header_byte(m_header_byte),
        .m_byte_offset(m_byte_offset),
        .m_last_byte  (m_last_byte)
    );

endmodule

// ----- bench/udp_frame_header_builder_test.sv -----
module udp_frame_header_builder_test;
    import ufhb_pkg::*;

    localparam int HDR_BYTES      = 42;
    localparam int SETTLE_CYCLES  = 8;       // margin for the front stage, queue and output register to go quiet
    localparam int LONG_HOLD      = 400;     // receiver hold-off for the back-pressure phases
    localparam int PHASE_ITEMS    = 43;
    localparam int PHASE_COUNT    = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 3'd7;   // index with no register behind it
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    typedef logic [0:HDR_BYTES-1][7:0] header_t;

    typedef struct packed {
        logic [7:0]          data;
        logic [OFFSET_W-1:0] offset;
        logic                last;
    } header_byte_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_SEND
    } row_kind_t;

    // one directed step: a register write, or an item with optional hand-typed fields
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [QUEUE_W-1:0]     queue;
        logic                   known_len;
        logic [15:0]            ip_len;
        logic [15:0]            udp_len;
        logic                   known_port;
        logic [15:0]            port;
    } directed_row_t;

    typedef enum int {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    localparam int DIRECTED_ROWS = 31;

    // after reset the lengths follow frame_len 60; the zero seed and the seed with a single
    // set bit make the port hash readable; lengths below 34 wrap
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd0,  1'b1, 16'h002E, 16'h001A, 1'b0, 16'h0},
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd63, 1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_WRITE, REG_PORT_SEED,  48'h0,              6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd0,  1'b0, 16'h0,    16'h0,    1'b1, 16'h0000},
        '{ROW_WRITE, REG_PORT_SEED,  48'h0100,           6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd0,  1'b0, 16'h0,    16'h0,    1'b1, 16'h8647},
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd63, 1'b0, 16'h0,    16'h0,    1'b1, 16'h91C0},
        '{ROW_WRITE, REG_PORT_SEED,  48'hABCD_0000_FFFF, 6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd42, 1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_WRITE, REG_FRAME_LEN,  48'h0,              6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd1,  1'b1, 16'hFFF2, 16'hFFDE, 1'b0, 16'h0},
        '{ROW_WRITE, REG_FRAME_LEN,  48'd33,             6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd2,  1'b1, 16'h0013, 16'hFFFF, 1'b0, 16'h0},
        '{ROW_WRITE, REG_FRAME_LEN,  48'd34,             6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd4,  1'b1, 16'h0014, 16'h0000, 1'b0, 16'h0},
        '{ROW_WRITE, REG_FRAME_LEN,  48'd4095,           6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd8,  1'b1, 16'h0FF1, 16'h0FDD, 1'b0, 16'h0},
        '{ROW_WRITE, REG_FRAME_LEN,  48'hFFFF_FFFF_F800, 6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd16, 1'b1, 16'h07F2, 16'h07DE, 1'b0, 16'h0},
        '{ROW_WRITE, REG_NONE,       48'hFFFF_FFFF_FFFF, 6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd21, 1'b1, 16'h07F2, 16'h07DE, 1'b0, 16'h0},
        '{ROW_WRITE, REG_DEST_MAC,   48'hFFFF_FFFF_FFFF, 6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_WRITE, REG_SOURCE_MAC, 48'hFFFF_FFFF_FFFF, 6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_WRITE, REG_DEST_IP,    48'hFFFF_FFFF_FFFF, 6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_WRITE, REG_SOURCE_IP,  48'hFFFF_FFFF_FFFF, 6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_WRITE, REG_DEST_PORT,  48'hFFFF_FFFF_FFFF, 6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd63, 1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_WRITE, REG_DEST_MAC,   48'h0123_4567_89AB, 6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_WRITE, REG_DEST_IP,    48'h0000_C0A8_0001, 6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_WRITE, REG_DEST_PORT,  48'h0,              6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0},
        '{ROW_SEND,  REG_DEST_MAC,   48'h0,              6'd0,  1'b0, 16'h0,    16'h0,    1'b0, 16'h0}
    };

    // block ports, all inputs known from time zero
    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [QUEUE_W-1:0]     s_queue_number = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [BYTE_W-1:0]      m_header_byte;
    logic [OFFSET_W-1:0]    m_byte_offset;
    logic                   m_last_byte;

    // bench state
    cfg_t         frame_cfg;              // shadow of the block's registers
    header_byte_t header_bytes_due [$];   // bytes still owed by the block, oldest first
    int           failures = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_orders = 0;        // bumped by the stimulus to ask for a long hold-off
    int           hold_served = 0;
    int           hold_left = 0;
    bit           cfg_busy = 0;           // write enable still high from the last write

    udp_frame_header_builder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_queue_number (s_queue_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_header_byte  (m_header_byte),
        .m_byte_offset  (m_byte_offset),
        .m_last_byte    (m_last_byte)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // whole 42-byte header for one queue number under the given settings
    function automatic header_t build_frame_header(input cfg_t c, input logic [QUEUE_W-1:0] q);
        header_t     h;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [15:0] seed_sw;
        logic [16:0] acc;
        logic [15:0] csum;
        logic [31:0] product;
        h = '0;
        for (int i = 0; i < 6; i++) begin
            h[i]     = c.dest_mac[47 - 8 * i -: 8];
            h[6 + i] = c.source_mac[47 - 8 * i -: 8];
        end
        {h[12], h[13]} = ETHERTYPE_IPV4;
        // lengths wrap at 16 bits when frame_len is short
        ip_len  = {4'b0, c.frame_len} - IP_HDR_OFS;
        udp_len = {4'b0, c.frame_len} - UDP_HDR_OFS;
        {h[14], h[15]} = WORD_VER_TOS;
        {h[16], h[17]} = ip_len;
        {h[22], h[23]} = WORD_TTL_UDP;
        for (int i = 0; i < 4; i++) begin
            h[26 + i] = c.source_ip[31 - 8 * i -: 8];
            h[30 + i] = c.dest_ip[31 - 8 * i -: 8];
        end
        // ones' complement sum over the ip header with the checksum field still zero
        acc = '0;
        for (int w = 14; w < 34; w += 2) begin
            acc = acc + {1'b0, h[w], h[w + 1]};
            if (acc > 17'h0FFFF)
                acc = acc - 17'h0FFFF;
        end
        csum = ~acc[15:0];
        {h[24], h[25]} = csum;
        // source port hash, sent low byte first
        seed_sw = {c.source_port_seed[7:0], c.source_port_seed[15:8]};
        product = (32'(seed_sw) + 32'(q)) * PORT_HASH;
        h[34] = product[7:0];
        h[35] = product[15:8];
        {h[36], h[37]} = c.dest_port;
        {h[38], h[39]} = udp_len;
        return h;
    endfunction

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_FULL: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            PACE_SEND_IDLE: begin
                send_idle_pct = 56;
                recv_stall_pct = 0;
            end
            PACE_RECV_STALL: begin
                send_idle_pct = 0;
                recv_stall_pct = 56;
            end
            default: begin
                send_idle_pct = 26;
                recv_stall_pct = 26;
            end
        endcase
    endtask

    // stop offering and wait until every owed byte is out and the block is quiet
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (header_bytes_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write; back-to-back writes keep the enable high
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        if (!cfg_busy)
            drain_pipeline();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_busy = 1;
        case (idx)
            REG_DEST_MAC:   frame_cfg.dest_mac = data[47:0];
            REG_SOURCE_MAC: frame_cfg.source_mac = data[47:0];
            REG_DEST_IP:    frame_cfg.dest_ip = data[31:0];
            REG_SOURCE_IP:  frame_cfg.source_ip = data[31:0];
            REG_DEST_PORT:  frame_cfg.dest_port = data[15:0];
            REG_PORT_SEED:  frame_cfg.source_port_seed = data[15:0];
            REG_FRAME_LEN:  frame_cfg.frame_len = data[11:0];
            default: ;      // unknown index, nothing changes
        endcase
    endtask

    // offer one item, wait for it to be taken, then queue its 42 bytes
    task automatic send_request(input directed_row_t r);
        int      gap;
        header_t h;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (cfg_busy) begin
            cfg_wr_en <= 1'b0;
            cfg_busy = 0;
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_queue_number <= r.queue;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        h = build_frame_header(frame_cfg, r.queue);
        // hand-typed fields override the predictor where a row gives them
        if (r.known_len) begin
            {h[16], h[17]} = r.ip_len;
            {h[38], h[39]} = r.udp_len;
        end
        if (r.known_port) begin
            h[34] = r.port[7:0];
            h[35] = r.port[15:8];
        end
        for (int i = 0; i < HDR_BYTES; i++)
            header_bytes_due.push_back('{h[i], OFFSET_W'(i), OFFSET_W'(i) == HDR_LAST});
    endtask

    // new settings for a random phase: extremes first, then random values
    // with junk above each register's width
    task automatic load_phase_settings(input int phase);
        logic [63:0]           junk;
        logic [11:0]           len;
        logic [CFG_DATA_W-1:0] all_ones;
        all_ones = '1;
        junk = {$urandom, $urandom};
        if (phase == 0) begin
            write_reg(REG_DEST_MAC, all_ones);
            write_reg(REG_SOURCE_MAC, all_ones);
            write_reg(REG_DEST_IP, all_ones);
            write_reg(REG_SOURCE_IP, all_ones);
            write_reg(REG_DEST_PORT, all_ones);
            write_reg(REG_PORT_SEED, all_ones);
            write_reg(REG_FRAME_LEN, 48'd2048);
        end else if (phase == 1) begin
            write_reg(REG_DEST_MAC, '0);
            write_reg(REG_SOURCE_MAC, '0);
            write_reg(REG_DEST_IP, '0);
            write_reg(REG_SOURCE_IP, '0);
            write_reg(REG_DEST_PORT, '0);
            write_reg(REG_PORT_SEED, '0);
            write_reg(REG_FRAME_LEN, 48'd60);
        end else begin
            // most phases keep frame_len in the legal range, some go anywhere
            len = (phase % 3 == 0) ? 12'($urandom) : 12'($urandom_range(60, 2048));
            write_reg(REG_DEST_MAC, 48'({$urandom, $urandom}));
            write_reg(REG_SOURCE_MAC, 48'({$urandom, $urandom}));
            write_reg(REG_DEST_IP, {junk[15:0], 32'($urandom)});
            write_reg(REG_SOURCE_IP, {junk[31:16], 32'($urandom)});
            write_reg(REG_DEST_PORT, {junk[47:16], 16'($urandom)});
            write_reg(REG_PORT_SEED, {junk[63:32], 16'($urandom)});
            write_reg(REG_FRAME_LEN, {junk[35:0], len});
            if (phase % 2 == 1)
                write_reg(REG_NONE, 48'({$urandom, $urandom}));
        end
    endtask

    // receiver: random stalls, plus a long counted hold-off when asked
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_served != hold_orders) begin
            m_ready <= 1'b0;
            hold_served = hold_served + 1;
            hold_left = LONG_HOLD - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result checker: every accepted byte against the oldest owed one
    always @(posedge aclk) begin : check_results
        header_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (header_bytes_due.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected header byte %02h at offset %0d last %0b",
                             m_header_byte, m_byte_offset, m_last_byte);
            end else begin
                want = header_bytes_due.pop_front();
                if (m_header_byte !== want.data || m_byte_offset !== want.offset ||
                    m_last_byte !== want.last) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("header byte mismatch: expected %02h/%0d/%0b got %02h/%0d/%0b",
                                 want.data, want.offset, want.last,
                                 m_header_byte, m_byte_offset, m_last_byte);
                end
            end
        end
    end

    // stimulus
    initial begin
        directed_row_t r;
        frame_cfg = '0;
        frame_cfg.dest_port = DEST_PORT_RST;
        frame_cfg.source_port_seed = PORT_SEED_RST;
        frame_cfg.frame_len = FRAME_LEN_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at full rate
        set_pace(PACE_FULL);
        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            if (DIRECTED[n].kind == ROW_WRITE)
                write_reg(DIRECTED[n].idx, DIRECTED[n].data);
            else
                send_request(DIRECTED[n]);
        end

        // random phases, walking through every pacing mode twice
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            load_phase_settings(phase);
            set_pace(pace_t'(phase % 4));
            // long receiver hold-off while the sender keeps pushing
            if (phase == 2 || phase == 5)
                hold_orders++;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = '0;
                r.kind = ROW_SEND;
                r.queue = QUEUE_W'($urandom_range(0, 63));
                send_request(r);
            end
        end

        drain_pipeline();
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
